// ===== design/mp2_pkg.sv =====
// Shared types and constants for the 2x2 max pooling stream unit.
package mp2_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 7;
  localparam int DIM_BITS       = 7;
  localparam int CHAN_CFG_BITS  = 6;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_BITS-1:0]      RESET_MAP_WIDTH     = 7'd24;
  localparam logic [DIM_BITS-1:0]      RESET_MAP_HEIGHT    = 7'd24;
  localparam logic [CHAN_CFG_BITS-1:0] RESET_CHANNEL_COUNT = 6'd6;

  typedef struct packed {
    logic [DIM_BITS-1:0]      width;
    logic [DIM_BITS-1:0]      height;
    logic [DIM_BITS-1:0]      width_used;
    logic [DIM_BITS-1:0]      height_used;
    logic [CHAN_CFG_BITS-1:0] channels;
  } geom_t;

  typedef struct packed {
    logic in_range;
    logic odd_col;
    logic odd_row;
    logic last;
  } pos_flags_t;

endpackage

// ===== design/mp2_cfg_regs.sv =====
// Configuration registers and the saturated map geometry derived from them.
module mp2_cfg_regs
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
  output geom_t                     geom
);

  logic [DIM_BITS-1:0]      map_width;
  logic [DIM_BITS-1:0]      map_height;
  logic [CHAN_CFG_BITS-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= RESET_MAP_WIDTH;
      map_height    <= RESET_MAP_HEIGHT;
      channel_count <= RESET_CHANNEL_COUNT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:     map_width     <= cfg_wdata;
        REG_MAP_HEIGHT:    map_height    <= cfg_wdata;
        REG_CHANNEL_COUNT: channel_count <= cfg_wdata[CHAN_CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_BITS-1:0]      w;
  logic [DIM_BITS-1:0]      h;
  logic [CHAN_CFG_BITS-1:0] n;

  always_comb begin
    w = map_width;
    if (map_width < DIM_BITS'(2)) w = DIM_BITS'(2);
    else if (int'(map_width) > MAX_WIDTH) w = DIM_BITS'(MAX_WIDTH);
    h = map_height;
    if (map_height < DIM_BITS'(2)) h = DIM_BITS'(2);
    else if (int'(map_height) > MAX_WIDTH) h = DIM_BITS'(MAX_WIDTH);
    n = channel_count;
    if (channel_count == '0) n = CHAN_CFG_BITS'(1);
    else if (int'(channel_count) > MAX_CHANNELS) n = CHAN_CFG_BITS'(MAX_CHANNELS);
  end

  assign geom.width       = w;
  assign geom.height      = h;
  assign geom.width_used  = {w[DIM_BITS-1:1], 1'b0};
  assign geom.height_used = {h[DIM_BITS-1:1], 1'b0};
  assign geom.channels    = n;

endmodule

// ===== design/mp2_position.sv =====
// Raster position counters and window classification of each accepted sample.
module mp2_position
  import mp2_pkg::*;
#(
  parameter int MAX_CHANNELS = 32,
  parameter int CW           = 6,
  parameter int CHW          = 5,
  parameter int AW           = 10
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           frame_start,
  input  geom_t          geom,
  output pos_flags_t     flags,
  output logic [AW-1:0]  slot,
  output logic [CHW-1:0] chan
);

  localparam int LW = ((CW > DIM_BITS) ? CW : DIM_BITS) + 1;
  localparam int NW = ((CHW > CHAN_CFG_BITS) ? CHW : CHAN_CFG_BITS) + 1;

  logic [CW-1:0]  col;
  logic [CW-1:0]  row;
  logic [CHW-1:0] ch;

  logic [CW-1:0]  col_cur;
  logic [CW-1:0]  row_cur;
  logic [CHW-1:0] ch_cur;

  logic [LW-1:0]  c_ext;
  logic [LW-1:0]  r_ext;
  logic [NW-1:0]  ch_ext;
  logic [LW-1:0]  w_ext;
  logic [LW-1:0]  h_ext;
  logic [LW-1:0]  wu_ext;
  logic [LW-1:0]  hu_ext;
  logic [NW-1:0]  n_ext;

  logic [NW-1:0]  ch_inc;
  logic           ch_wrap;
  logic [LW-1:0]  c_inc;
  logic           c_wrap;
  logic [LW-1:0]  r_inc;

  logic [CW-1:0]  col_next;
  logic [CW-1:0]  row_next;
  logic [CHW-1:0] ch_next;

  always_comb begin
    col_cur = frame_start ? '0 : col;
    row_cur = frame_start ? '0 : row;
    ch_cur  = frame_start ? '0 : ch;

    c_ext  = LW'(col_cur);
    r_ext  = LW'(row_cur);
    ch_ext = NW'(ch_cur);
    w_ext  = LW'(geom.width);
    h_ext  = LW'(geom.height);
    wu_ext = LW'(geom.width_used);
    hu_ext = LW'(geom.height_used);
    n_ext  = NW'(geom.channels);

    flags.in_range = (c_ext < wu_ext) && (r_ext < hu_ext) && (ch_ext < n_ext);
    flags.odd_col  = col_cur[0];
    flags.odd_row  = row_cur[0];
    flags.last     = (r_ext == hu_ext - LW'(1)) && (c_ext == wu_ext - LW'(1)) &&
                     (ch_ext == n_ext - NW'(1));

    ch_inc   = ch_ext + NW'(1);
    ch_wrap  = ch_inc >= n_ext;
    ch_next  = ch_wrap ? '0 : CHW'(ch_inc);
    c_inc    = c_ext + LW'(ch_wrap);
    c_wrap   = c_inc >= w_ext;
    col_next = c_wrap ? '0 : CW'(c_inc);
    r_inc    = r_ext + LW'(ch_wrap && c_wrap);
    row_next = (r_inc >= h_ext) ? '0 : CW'(r_inc);
  end

  assign slot = AW'(AW'(col_cur >> 1) * AW'(MAX_CHANNELS) + AW'(ch_cur));
  assign chan = ch_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ch  <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      ch  <= ch_next;
    end
  end

endmodule

// ===== design/mp2_pool_core.sv =====
// Sample holding registers, row buffer, max compare and result register.
module mp2_pool_core
  import mp2_pkg::*;
#(
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_CHANNELS = 32,
  parameter int ROW_SLOTS    = 1024,
  parameter int CHW          = 5,
  parameter int AW           = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  pos_flags_t             flags,
  input  logic [AW-1:0]          slot,
  input  logic [CHW-1:0]         chan,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_value,
  output logic                   out_last
);

  logic [SAMPLE_BITS-1:0] pending [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] row_buf [ROW_SLOTS];

  logic                   s1_valid;
  pos_flags_t             s1_flags;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [AW-1:0]          s1_slot;
  logic [CHW-1:0]         s1_chan;
  logic [SAMPLE_BITS-1:0] s1_row;

  logic [SAMPLE_BITS-1:0] pend_rd;
  logic [SAMPLE_BITS-1:0] pair_max;
  logic [SAMPLE_BITS-1:0] win_max;
  logic                   s1_result;
  logic                   s1_write;
  logic                   s1_advance;

  always_comb begin
    pend_rd    = pending[s1_chan];
    pair_max   = ($signed(pend_rd) >= $signed(s1_sample)) ? pend_rd : s1_sample;
    win_max    = ($signed(s1_row) >= $signed(pair_max)) ? s1_row : pair_max;
    s1_result  = s1_valid && s1_flags.in_range && s1_flags.odd_col && s1_flags.odd_row;
    s1_write   = s1_valid && s1_flags.in_range && s1_flags.odd_col && !s1_flags.odd_row;
    s1_advance = !s1_result || !out_valid || out_ready;
    ready      = !s1_valid || s1_advance;
  end

  always_ff @(posedge clk) begin
    if (accept && flags.in_range && !flags.odd_col) begin
      pending[chan] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_write) begin
      row_buf[s1_slot] <= pair_max;
    end
    if (accept) begin
      s1_row <= row_buf[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags  <= flags;
      s1_sample <= sample;
      s1_slot   <= slot;
      s1_chan   <= chan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_result && s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_result && s1_advance) begin
      out_value <= win_max;
      out_last  <= s1_flags.last;
    end
  end

endmodule

// ===== design/max_pool_2x2_stream_unit.sv =====
// 2x2 stride-2 max pooling over a streamed signed feature map: top level.
// Samples enter in raster order, channel innermost, one per clock; the unit
// accepts a sample every cycle while the output side keeps up. A pooled
// result, taken at the odd row and odd column of its window, passes the
// registered row-buffer read, then the result register. Results come out
// row-major, channel innermost, with tlast on the final window of a map. A
// trailing odd row or column is dropped. tuser marks the first sample of a
// map and clears the position counters. The user must write width, height and
// channel count through the configuration port only while the unit is idle,
// not enforced by the unit. Out-of-range values saturate to supported sizes.
// The row buffer holds (MAX_WIDTH/2)*MAX_CHANNELS partial maxima in one memory.
module max_pool_2x2_stream_unit
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_CHANNELS = 32,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample
  input  logic                                 s_tuser,  // frame_start
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // pooled_value
  output logic                                 m_tlast,
  input  logic                                 cfg_wen,
  input  logic [CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [CFG_DATA_BITS-1:0]             cfg_wdata
);

  localparam int DW        = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int CHW       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_SLOTS = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int AW        = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;

  geom_t                  geom;
  pos_flags_t             flags;
  logic [AW-1:0]          slot;
  logic [CHW-1:0]         chan;
  logic                   accept;
  logic [SAMPLE_BITS-1:0] pooled_value;

  assign accept = s_tvalid && s_tready;

  mp2_cfg_regs #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  mp2_position #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW),
    .CHW          (CHW),
    .AW           (AW)
  ) u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_tuser),
    .geom        (geom),
    .flags       (flags),
    .slot        (slot),
    .chan        (chan)
  );

  mp2_pool_core #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .ROW_SLOTS    (ROW_SLOTS),
    .CHW          (CHW),
    .AW           (AW)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .flags     (flags),
    .slot      (slot),
    .chan      (chan),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (pooled_value),
    .out_last  (m_tlast)
  );

  assign m_tdata = DW'(pooled_value);

endmodule

// ===== bench/tb_max_pool_2x2_stream_unit.sv =====
// Testbench for the 2x2 max pooling stream unit: directed table, then random maps.
`timescale 1ns / 100ps

module tb_max_pool_2x2_stream_unit;
  import mp2_pkg::*;

  localparam int MAX_WIDTH      = 64;
  localparam int MAX_CHANNELS   = 32;
  localparam int ROW_SLOTS      = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int PRESSURE_AT    = 300;
  localparam int QUIET_FROM     = 600;
  localparam int QUIET_TO       = 850;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [6:0]  w;
    logic [6:0]  h;
    logic [6:0]  c;
    logic [15:0] sample;
    logic        fs;
    bit          typed;
    logic [15:0] want;
    logic        want_last;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } pooled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;  // sample
  logic s_tuser = 1'b0;       // frame_start
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;       // pooled_value
  logic m_tlast;
  logic cfg_wen = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  logic row_typed = 1'b0;
  logic [15:0] row_want = '0;
  logic row_want_last = 1'b0;
  logic hold_req = 1'b0;
  logic quiet = 1'b0;

  logic [6:0] geo_w = RESET_MAP_WIDTH;
  logic [6:0] geo_h = RESET_MAP_HEIGHT;
  logic [5:0] geo_c = RESET_CHANNEL_COUNT;
  logic [5:0] col_pos = '0;
  logic [5:0] row_pos = '0;
  logic [4:0] chan_pos = '0;
  logic [15:0] held_sample [MAX_CHANNELS];
  logic [15:0] row_max_buf [ROW_SLOTS];

  pooled_t pooled_q[$];
  int mismatches = 0;
  int item_count = 0;
  int stall_cycles = 0;

  max_pool_2x2_stream_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int saturate(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [15:0] max_of(input logic [15:0] a, input logic [15:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic int map_items(input logic [6:0] w, input logic [6:0] h, input logic [6:0] c);
    return saturate(int'(w), 2, MAX_WIDTH) * saturate(int'(h), 2, MAX_WIDTH) *
           saturate(int'(c[5:0]), 1, MAX_CHANNELS);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [6:0] w, input logic [6:0] h,
                                        input logic [6:0] c);
    stim_row_t r;
    r = '{ROW_CFG, w, h, c, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [15:0] s, input logic fs);
    stim_row_t r;
    r = '{ROW_ITEM, 7'd0, 7'd0, 7'd0, s, fs, 1'b0, 16'h0000, 1'b0};
    return r;
  endfunction

  function automatic stim_row_t want_row(input logic [15:0] s, input logic fs,
                                         input logic [15:0] want, input logic last);
    stim_row_t r;
    r = '{ROW_ITEM, 7'd0, 7'd0, 7'd0, s, fs, 1'b1, want, last};
    return r;
  endfunction

  // Advance the pooling state by one sample and report the window maximum, if any.
  task automatic pool_step(input logic [15:0] s, input logic fs, output bit got,
                           output pooled_t res);
    int w, h, cn, wu, hu, c, r, ch, slot;
    w = saturate(int'(geo_w), 2, MAX_WIDTH);
    h = saturate(int'(geo_h), 2, MAX_WIDTH);
    cn = saturate(int'(geo_c), 1, MAX_CHANNELS);
    wu = w & ~1;
    hu = h & ~1;
    got = 1'b0;
    res = '0;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
      chan_pos = '0;
    end
    c = int'(col_pos);
    r = int'(row_pos);
    ch = int'(chan_pos);
    if (c < wu && r < hu && ch < cn) begin
      slot = (c / 2) * MAX_CHANNELS + ch;
      if (c % 2 == 0) begin
        held_sample[ch] = s;
      end else if (r % 2 == 0) begin
        row_max_buf[slot] = max_of(held_sample[ch], s);
      end else begin
        res.value = max_of(row_max_buf[slot], max_of(held_sample[ch], s));
        res.last = (r == hu - 1 && c == wu - 1 && ch == cn - 1);
        got = 1'b1;
      end
    end
    ch++;
    if (ch >= cn) begin
      ch = 0;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
    end
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    col_pos = 6'(c);
    row_pos = 6'(r);
    chan_pos = 5'(ch);
  endtask

  initial begin
    foreach (held_sample[i]) held_sample[i] = '0;
    foreach (row_max_buf[i]) row_max_buf[i] = '0;
  end

  always @(posedge clk) begin
    bit got;
    pooled_t res;
    pooled_t want;
    if (!rst) begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_MAP_WIDTH:     geo_w = cfg_wdata;
          REG_MAP_HEIGHT:    geo_h = cfg_wdata;
          REG_CHANNEL_COUNT: geo_c = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        pool_step(s_tdata, s_tuser, got, res);
        if (row_typed) pooled_q.push_back('{row_want, row_want_last});
        else if (got) pooled_q.push_back(res);
      end
      if (m_tvalid && m_tready) begin
        if (pooled_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %h last %b",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = pooled_q.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: pooled_value mismatch: expected %h, got %h",
                     $time, want.value, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last_of_map mismatch: expected %b, got %b",
                     $time, want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("max_pool_2x2_stream_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= quiet || ($urandom_range(99) >= 37);
    end
  end

  task automatic offer(input logic [15:0] v, input logic fs, input bit typed,
                       input logic [15:0] tv, input logic tl);
    if (item_count == PRESSURE_AT) hold_req <= 1'b1;
    quiet <= (item_count >= QUIET_FROM && item_count < QUIET_TO);
    if (!quiet && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tuser <= fs;
    row_typed <= typed;
    row_want <= tv;
    row_want_last <= tl;
    do @(posedge clk); while (!s_tready);
    item_count++;
  endtask

  // Wait until every pooled result is out and the pipeline has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [6:0] w, input logic [6:0] h, input logic [6:0] c);
    cfg_wen <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    stim_row_t plan[$];
    logic [6:0] w, h, c;
    int n, cut, pick, maps;
    bit need_fs;
    logic fs;

    // 2x2 maps, single channel: extremes, map following map, restart mid-map
    plan.push_back(cfg_row(7'd2, 7'd2, 7'd1));
    plan.push_back(item_row(16'h8000, 1'b1));
    plan.push_back(item_row(16'h8000, 1'b0));
    plan.push_back(item_row(16'h8000, 1'b0));
    plan.push_back(want_row(16'h8000, 1'b0, 16'h8000, 1'b1));
    plan.push_back(item_row(16'hFFFF, 1'b0));
    plan.push_back(item_row(16'h8000, 1'b0));
    plan.push_back(item_row(16'h7FFF, 1'b0));
    plan.push_back(want_row(16'h0000, 1'b0, 16'h7FFF, 1'b1));
    plan.push_back(item_row(16'h0007, 1'b1));
    plan.push_back(item_row(16'h0003, 1'b1));
    plan.push_back(item_row(16'hFFFE, 1'b0));
    plan.push_back(item_row(16'h0001, 1'b0));
    plan.push_back(want_row(16'h0006, 1'b0, 16'h0006, 1'b1));
    // odd width drops the last column; height and channel count saturate
    plan.push_back(cfg_row(7'd3, 7'd1, 7'd0));
    plan.push_back(item_row(16'h000A, 1'b1));
    plan.push_back(item_row(16'hFFEC, 1'b0));
    plan.push_back(item_row(16'h270F, 1'b0));
    plan.push_back(item_row(16'hFFE2, 1'b0));
    plan.push_back(want_row(16'h0004, 1'b0, 16'h000A, 1'b1));
    plan.push_back(item_row(16'h7FFF, 1'b0));
    // shrink the width mid-map so the column counter lands past the limit
    plan.push_back(item_row(16'h0005, 1'b1));
    plan.push_back(item_row(16'h0009, 1'b0));
    plan.push_back(cfg_row(7'd2, 7'd1, 7'd0));
    plan.push_back(item_row(16'h1234, 1'b0));
    plan.push_back(item_row(16'hFF00, 1'b0));
    plan.push_back(item_row(16'h0042, 1'b0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        set_geometry(plan[i].w, plan[i].h, plan[i].c);
      end else begin
        offer(plan[i].sample, plan[i].fs, plan[i].typed, plan[i].want, plan[i].want_last);
      end
    end

    while (item_count < plan.size() + RANDOM_ITEMS) begin
      pick = int'($urandom_range(99));
      if (pick < 5) begin
        w = ($urandom_range(1) == 0) ? 7'd64 : 7'd127;
        h = 7'd2;
        c = 7'd1;
      end else if (pick < 10) begin
        w = 7'd2;
        h = ($urandom_range(1) == 0) ? 7'd64 : 7'd100;
        c = 7'd1;
      end else if (pick < 15) begin
        w = 7'd2;
        h = 7'($urandom_range(2, 3));
        c = ($urandom_range(1) == 0) ? 7'd32 : 7'd63;
      end else if (pick < 22) begin
        w = 7'($urandom_range(1));
        h = 7'($urandom_range(1));
        c = ($urandom_range(1) == 0) ? 7'd0 : 7'(64 + $urandom_range(1, 3));
      end else begin
        w = 7'($urandom_range(2, 9));
        h = 7'($urandom_range(2, 9));
        c = 7'($urandom_range(1, 4));
      end
      drain();
      set_geometry(w, h, c);
      need_fs = 1'b1;
      n = map_items(w, h, c);
      maps = int'($urandom_range(1, 3));
      for (int m = 0; m < maps; m++) begin
        cut = ($urandom_range(99) < 8) ? int'($urandom_range(1, n)) : n;
        for (int k = 0; k < cut && item_count < plan.size() + RANDOM_ITEMS; k++) begin
          fs = (k == 0 && (need_fs || $urandom_range(99) < 60)) || ($urandom_range(299) == 0);
          offer(rand_sample(), fs, 1'b0, 16'h0000, 1'b0);
        end
        need_fs = (cut != n);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("max_pool_2x2_stream_unit test passed");
    end else begin
      $display("max_pool_2x2_stream_unit test failed");
    end
    $finish;
  end

endmodule

// ===== max_pool_2x2_stream_unit.f =====
design/mp2_pkg.sv
design/mp2_cfg_regs.sv
design/mp2_position.sv
design/mp2_pool_core.sv
design/max_pool_2x2_stream_unit.sv
bench/tb_max_pool_2x2_stream_unit.sv
